// File: rtl/core/imx_pkg.sv
`default_nettype none
package imx_pkg;

	localparam int MAX_DIM    = 8;
	localparam int DEPTH      = MAX_DIM * MAX_DIM;
	localparam int IDX_W      = $clog2(MAX_DIM);
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int DATA_W     = 32;
	localparam int DIM_W      = 4;
	localparam int MODE_W     = 2;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;
	localparam int S_BITS     = 2 * IDX_W + DATA_W;
	localparam int S_TDATA_W  = ((S_BITS + 7) / 8) * 8;
	localparam int M_BITS     = DATA_W + 2 * IDX_W;
	localparam int M_TDATA_W  = ((M_BITS + 7) / 8) * 8;

	localparam logic [MODE_W-1:0] OP_ADD = 2'd0;
	localparam logic [MODE_W-1:0] OP_SUB = 2'd1;
	localparam logic [MODE_W-1:0] OP_MUL = 2'd2;

	localparam logic [CMD_W-1:0] CMD_WR_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WR_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RUN  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_A  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_B  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OP_MODE = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              valid;
		logic              clear;
		logic [MODE_W-1:0] op;
	} alu_ctrl_t;

	function automatic logic dim_ok(logic [DIM_W-1:0] d);
		return (d != '0) && (d <= DIM_W'(MAX_DIM));
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
		return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/integer_matrix_add_sub_multiply_core.sv
// Matrix engine for two signed 32-bit matrices of up to 8x8. Element writes (tuser 0 for A,
// 1 for B) are taken while the engine is idle. A run (tuser 2) streams the result in
// row-major order with tlast on the final element; tuser on the output flags non-conforming
// dimensions, in which case a single zero result is sent. Each result element is computed by
// issuing n reads, n being cols_a for multiply and 1 for add/subtract, through the one
// registered-read memory port per matrix that feeds a single multiply/add unit and accumulator;
// the read and ALU stages then drain and the output register is loaded, which waits while
// the output holds off.
// The input is not ready until the last result of a run has been handed to the output register.
`default_nettype none
module integer_matrix_add_sub_multiply_core
	import imx_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,   // row_index, col_index, elem_value, zero pad
	input  wire logic [CMD_W-1:0]      s_tuser,   // cmd
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [M_TDATA_W-1:0]  m_tdata,   // result_value, out_row, out_col, zero pad
	output logic                       m_tlast,
	output logic                       m_tuser,   // dim_error
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [DIM_W-1:0]  rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	logic [MODE_W-1:0] op_mode_q;

	logic [DATA_W-1:0] mem_a [DEPTH];
	logic [DATA_W-1:0] mem_b [DEPTH];
	logic [DATA_W-1:0] rd_a_s1, rd_b_s1;
	logic              v_s1;

	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic             err_q;

	logic              m_valid_q;
	logic [DATA_W-1:0] m_value_q;
	logic [IDX_W-1:0]  m_row_q, m_col_q;
	logic              m_last_q, m_err_q;

	logic [IDX_W-1:0]  in_row, in_col;
	logic [DATA_W-1:0] in_val;
	logic              in_fire, run_ok, is_mul;
	logic [DIM_W-1:0]  inner_n, out_rows, out_cols;
	logic              k_last, j_last, i_last, elem_last;
	logic              issue, emit_load, out_free, idx_ok;
	logic [ADDR_W-1:0] addr_a, addr_b, waddr;
	alu_ctrl_t         alu_ctrl;
	logic              alu_busy;
	logic [DATA_W-1:0] acc;

	assign in_row  = s_tdata[IDX_W-1:0];
	assign in_col  = s_tdata[2*IDX_W-1:IDX_W];
	assign in_val  = s_tdata[2*IDX_W+DATA_W-1:2*IDX_W];
	assign in_fire = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign is_mul   = (op_mode_q == OP_MUL);
	assign inner_n  = is_mul ? cols_a_q : DIM_W'(1);
	assign out_rows = rows_a_q;
	assign out_cols = is_mul ? cols_b_q : cols_a_q;

	always_comb begin
		run_ok = dim_ok(rows_a_q) && dim_ok(cols_a_q) && dim_ok(rows_b_q) && dim_ok(cols_b_q);
		priority if (op_mode_q == OP_ADD || op_mode_q == OP_SUB) begin
			run_ok = run_ok && (rows_a_q == rows_b_q) && (cols_a_q == cols_b_q);
		end else if (op_mode_q == OP_MUL) begin
			run_ok = run_ok && (cols_a_q == rows_b_q);
		end else begin
			run_ok = 1'b0;
		end
	end

	assign k_last    = (DIM_W'(k_q) + DIM_W'(1)) == inner_n;
	assign j_last    = (DIM_W'(j_q) + DIM_W'(1)) == out_cols;
	assign i_last    = (DIM_W'(i_q) + DIM_W'(1)) == out_rows;
	assign elem_last = i_last && j_last;
	assign out_free  = !m_valid_q || m_tready;

	assign idx_ok = (DIM_W'(in_row) < DIM_W'(MAX_DIM)) && (DIM_W'(in_col) < DIM_W'(MAX_DIM));
	assign waddr  = cell_addr(in_row, in_col);
	assign addr_a = is_mul ? cell_addr(i_q, k_q) : cell_addr(i_q, j_q);
	assign addr_b = is_mul ? cell_addr(k_q, j_q) : cell_addr(i_q, j_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && s_tuser == CMD_RUN) begin
					state_d = run_ok ? ST_ISSUE : ST_EMIT;
				end
			end
			ST_ISSUE: begin
				if (k_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !alu_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = (err_q || elem_last) ? ST_IDLE : ST_ISSUE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready  = 1'b0;
		issue     = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			ST_IDLE:  s_tready  = 1'b1;
			ST_ISSUE: issue     = 1'b1;
			ST_EMIT:  emit_load = out_free;
			default: ;
		endcase
	end

	assign alu_ctrl.valid = v_s1;
	assign alu_ctrl.clear = (state_q == ST_IDLE) || emit_load;
	assign alu_ctrl.op    = op_mode_q;

	imx_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (alu_ctrl),
		.a      (rd_a_s1),
		.b      (rd_b_s1),
		.busy   (alu_busy),
		.acc    (acc)
	);

	always_ff @(posedge clk) begin
		if (in_fire && s_tuser == CMD_WR_A && idx_ok) begin
			mem_a[waddr] <= in_val;
		end
		rd_a_s1 <= mem_a[addr_a];
	end

	always_ff @(posedge clk) begin
		if (in_fire && s_tuser == CMD_WR_B && idx_ok) begin
			mem_b[waddr] <= in_val;
		end
		rd_b_s1 <= mem_b[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q  <= DIM_W'(2);
			cols_a_q  <= DIM_W'(2);
			rows_b_q  <= DIM_W'(2);
			cols_b_q  <= DIM_W'(2);
			op_mode_q <= OP_ADD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROWS_A:  rows_a_q  <= cfg_data;
				REG_COLS_A:  cols_a_q  <= cfg_data;
				REG_ROWS_B:  rows_b_q  <= cfg_data;
				REG_COLS_B:  cols_b_q  <= cfg_data;
				REG_OP_MODE: op_mode_q <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			v_s1      <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			err_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			if (state_q == ST_IDLE && in_fire && s_tuser == CMD_RUN) begin
				i_q   <= '0;
				j_q   <= '0;
				k_q   <= '0;
				err_q <= !run_ok;
			end
			if (issue) begin
				k_q <= k_last ? '0 : k_q + IDX_W'(1);
			end
			if (emit_load) begin
				if (j_last) begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			m_value_q <= err_q ? '0 : acc;
			m_row_q   <= err_q ? '0 : i_q;
			m_col_q   <= err_q ? '0 : j_q;
			m_last_q  <= err_q || elem_last;
			m_err_q   <= err_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_TDATA_W'({m_col_q, m_row_q, m_value_q});
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_err_q;

endmodule
`default_nettype wire

// File: rtl/core/imx_alu.sv
`default_nettype none
module imx_alu
	import imx_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire alu_ctrl_t                ctrl,
	input  wire logic        [DATA_W-1:0] a,
	input  wire logic        [DATA_W-1:0] b,
	output logic                          busy,
	output logic             [DATA_W-1:0] acc
);

	logic              v_s2;
	logic [DATA_W-1:0] res_s2;
	logic [DATA_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_ADD:  res_s2 <= a + b;
			OP_SUB:  res_s2 <= a - b;
			default: res_s2 <= DATA_W'(a * b);
		endcase
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + res_s2;
		end
	end

	assign busy = v_s2;
	assign acc  = acc_q;

endmodule
`default_nettype wire

// File: tb/integer_matrix_add_sub_multiply_core_test.sv
`timescale 1ns / 100ps
module integer_matrix_add_sub_multiply_core_test;
	import imx_pkg::*;

	localparam logic [CMD_W-1:0]     CMD_NOP      = 2'd3;
	localparam logic [MODE_W-1:0]    OP_SPARE     = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int RANDOM_ITEMS  = 130;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 5000;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic              last;
		logic              err;
	} mx_result_t;

	localparam mx_result_t DIM_ERR_RESULT = '{value: '0, row: '0, col: '0, last: 1'b1, err: 1'b1};

	typedef struct packed {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic [CMD_W-1:0]      cmd;
		logic [IDX_W-1:0]      row;
		logic [IDX_W-1:0]      col;
		logic [DATA_W-1:0]     val;
		logic                  typed;
		mx_result_t            want;
	} step_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [CMD_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// shadow of the block
	logic [DATA_W-1:0] mat_a [DEPTH];
	logic [DATA_W-1:0] mat_b [DEPTH];
	bit   [DEPTH-1:0]  a_loaded = '0;
	bit   [DEPTH-1:0]  b_loaded = '0;
	logic [DIM_W-1:0]  dim_ra = 4'd2;
	logic [DIM_W-1:0]  dim_ca = 4'd2;
	logic [DIM_W-1:0]  dim_rb = 4'd2;
	logic [DIM_W-1:0]  dim_cb = 4'd2;
	logic [MODE_W-1:0] op_sel = OP_ADD;

	mx_result_t pending_elems[$];
	step_t      directed_steps[$];
	int         mismatches = 0;
	int         items_sent = 0;
	int         burst_left = 0;
	bit         gapless = 1'b0;
	bit         hold_off_req = 1'b0;

	integer_matrix_add_sub_multiply_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic step_t cfg_step(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.reg_idx = idx;
		s.reg_val = data;
		return s;
	endfunction

	function automatic step_t item_step(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row,
			logic [IDX_W-1:0] col, logic [DATA_W-1:0] val);
		step_t s;
		s = '0;
		s.cmd = cmd;
		s.row = row;
		s.col = col;
		s.val = val;
		return s;
	endfunction

	function automatic step_t checked_run(mx_result_t want);
		step_t s;
		s = item_step(CMD_RUN, '0, '0, '0);
		s.typed = 1'b1;
		s.want = want;
		return s;
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic dims_conform();
		logic ok;
		ok = dim_ra != 0 && dim_ra <= MAX_DIM && dim_ca != 0 && dim_ca <= MAX_DIM &&
			dim_rb != 0 && dim_rb <= MAX_DIM && dim_cb != 0 && dim_cb <= MAX_DIM;
		case (op_sel)
			OP_ADD, OP_SUB: ok = ok && dim_ra == dim_rb && dim_ca == dim_cb;
			OP_MUL: ok = ok && dim_ca == dim_rb;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	task automatic predict_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] val);
		int out_rows;
		int out_cols;
		logic [DATA_W-1:0] acc;
		mx_result_t r;
		case (cmd)
			CMD_WR_A: begin
				mat_a[{row, col}] = val;
				a_loaded[{row, col}] = 1'b1;
			end
			CMD_WR_B: begin
				mat_b[{row, col}] = val;
				b_loaded[{row, col}] = 1'b1;
			end
			CMD_RUN: begin
				if (!dims_conform()) begin
					pending_elems.push_back(DIM_ERR_RESULT);
				end else begin
					out_rows = int'(dim_ra);
					out_cols = int'((op_sel == OP_MUL) ? dim_cb : dim_ca);
					for (int i = 0; i < out_rows; i++) begin
						for (int j = 0; j < out_cols; j++) begin
							if (op_sel == OP_ADD) begin
								acc = mat_a[ADDR_W'(i * MAX_DIM + j)] +
									mat_b[ADDR_W'(i * MAX_DIM + j)];
							end else if (op_sel == OP_SUB) begin
								acc = mat_a[ADDR_W'(i * MAX_DIM + j)] -
									mat_b[ADDR_W'(i * MAX_DIM + j)];
							end else begin
								acc = '0;
								for (int k = 0; k < dim_ca; k++)
									acc = acc + mat_a[ADDR_W'(i * MAX_DIM + k)] *
										mat_b[ADDR_W'(k * MAX_DIM + j)];
							end
							r.value = acc;
							r.row = IDX_W'(i);
							r.col = IDX_W'(j);
							r.last = (i == out_rows - 1) && (j == out_cols - 1);
							r.err = 1'b0;
							pending_elems.push_back(r);
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
	endtask

	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] val, input bit predicted);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = gapless ? 0 : $urandom_range(0, 4);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= S_TDATA_W'({val, col, row});
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (cmd != CMD_NOP)
			items_sent++;
		if (predicted)
			predict_item(cmd, row, col, val);
	endtask

	task automatic stray_write();
		logic [CMD_W-1:0] cmd;
		cmd = ($urandom_range(0, 7) == 0) ? CMD_NOP : ($urandom_range(0, 1) ? CMD_WR_B : CMD_WR_A);
		send_item(cmd, IDX_W'($urandom()), IDX_W'($urandom()), pick_value(), 1'b1);
	endtask

	// write every cell the next run reads that holds nothing yet
	task automatic load_operands();
		for (int i = 0; i < MAX_DIM; i++) begin
			for (int j = 0; j < MAX_DIM; j++) begin
				if (i < dim_ra && j < dim_ca && !a_loaded[ADDR_W'(i * MAX_DIM + j)])
					send_item(CMD_WR_A, IDX_W'(i), IDX_W'(j), pick_value(), 1'b1);
				if (((op_sel == OP_MUL) ? (i < dim_rb && j < dim_cb) : (i < dim_ra && j < dim_ca))
						&& !b_loaded[ADDR_W'(i * MAX_DIM + j)])
					send_item(CMD_WR_B, IDX_W'(i), IDX_W'(j), pick_value(), 1'b1);
			end
		end
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ROWS_A:  dim_ra = data;
			REG_COLS_A:  dim_ca = data;
			REG_ROWS_B:  dim_rb = data;
			REG_COLS_B:  dim_cb = data;
			REG_OP_MODE: op_sel = data[MODE_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_elems.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	always @(posedge clk) begin : result_check
		mx_result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_elems.size() == 0) begin
				report_mismatch("result with nothing pending", m_tdata[DATA_W-1:0], '0);
			end else begin
				want = pending_elems.pop_front();
				if (m_tdata[DATA_W-1:0] !== want.value)
					report_mismatch("result_value", m_tdata[DATA_W-1:0], want.value);
				if (m_tdata[DATA_W +: IDX_W] !== want.row)
					report_mismatch("out_row", DATA_W'(m_tdata[DATA_W +: IDX_W]),
						DATA_W'(want.row));
				if (m_tdata[DATA_W + IDX_W +: IDX_W] !== want.col)
					report_mismatch("out_col", DATA_W'(m_tdata[DATA_W + IDX_W +: IDX_W]),
						DATA_W'(want.col));
				if (m_tlast !== want.last)
					report_mismatch("last_elem", DATA_W'(m_tlast), DATA_W'(want.last));
				if (m_tuser !== want.err)
					report_mismatch("dim_error", DATA_W'(m_tuser), DATA_W'(want.err));
			end
		end
	end

	initial begin : receiver
		logic [7:0] mask;
		int pos;
		mask = 8'hFF;
		pos = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (pos == 0)
					mask = $urandom_range(0, 2) == 0 ? 8'hFF : (8'($urandom()) | 8'h11);
				m_tready <= mask[3'(pos % 8)];
				pos = (pos + 1) % 32;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		step_t st;
		logic [DIM_W-1:0] ra, ca, rb, cb, bad;
		logic [MODE_W-1:0] op;
		int phase_no, runs, item_target;
		bit busy, pressure_done;

		// after reset: 2x2, add
		directed_steps = '{
			item_step(CMD_WR_A, 3'd0, 3'd0, 32'h7FFF_FFFF),
			item_step(CMD_WR_A, 3'd0, 3'd1, 32'h8000_0000),
			item_step(CMD_WR_A, 3'd1, 3'd0, 32'hFFFF_FFFF),
			item_step(CMD_WR_A, 3'd1, 3'd1, 32'h0000_0000),
			item_step(CMD_WR_B, 3'd0, 3'd0, 32'h0000_0001),
			item_step(CMD_WR_B, 3'd0, 3'd1, 32'h8000_0000),
			item_step(CMD_WR_B, 3'd1, 3'd0, 32'hFFFF_FFFF),
			item_step(CMD_WR_B, 3'd1, 3'd1, 32'h7FFF_FFFF),
			item_step(CMD_WR_A, 3'd7, 3'd7, 32'h5A5A_5A5A),
			item_step(CMD_WR_B, 3'd7, 3'd7, 32'hA5A5_A5A5),
			item_step(CMD_NOP, 3'd7, 3'd7, 32'hFFFF_FFFF),
			item_step(CMD_RUN, 3'd7, 3'd7, 32'hFFFF_FFFF),
			cfg_step(REG_OP_MODE, CFG_DATA_W'(OP_SUB)),
			item_step(CMD_RUN, 3'd0, 3'd0, 32'h0),
			cfg_step(REG_OP_MODE, {2'b11, OP_MUL}),
			item_step(CMD_RUN, 3'd0, 3'd0, 32'h0),
			cfg_step(REG_OP_MODE, CFG_DATA_W'(OP_SPARE)),
			checked_run(DIM_ERR_RESULT),
			cfg_step(REG_OP_MODE, CFG_DATA_W'(OP_ADD)),
			cfg_step(REG_ROWS_A, 4'd0),
			checked_run(DIM_ERR_RESULT),
			cfg_step(REG_ROWS_A, 4'd9),
			checked_run(DIM_ERR_RESULT),
			cfg_step(REG_ROWS_A, 4'd2),
			cfg_step(REG_OP_MODE, CFG_DATA_W'(OP_MUL)),
			cfg_step(REG_COLS_B, 4'd15),
			checked_run(DIM_ERR_RESULT),
			cfg_step(REG_ROWS_A, 4'd1),
			cfg_step(REG_COLS_A, 4'd1),
			cfg_step(REG_ROWS_B, 4'd1),
			cfg_step(REG_COLS_B, 4'd1),
			cfg_step(REG_OP_MODE, CFG_DATA_W'(OP_ADD)),
			checked_run(mx_result_t'{value: 32'h8000_0000, row: '0, col: '0, last: 1'b1, err: 1'b0}),
			cfg_step(REG_OP_MODE, CFG_DATA_W'(OP_MUL)),
			cfg_step(REG_COLS_A, 4'd2),
			checked_run(DIM_ERR_RESULT),
			cfg_step(REG_OP_MODE, CFG_DATA_W'(OP_ADD)),
			cfg_step(REG_ROWS_A, 4'd2),
			cfg_step(REG_COLS_B, 4'd2),
			checked_run(DIM_ERR_RESULT),
			cfg_step(REG_SPARE_HI, 4'hF),
			cfg_step(REG_ROWS_B, 4'd2),
			item_step(CMD_RUN, 3'd0, 3'd0, 32'h0),
			cfg_step(REG_ROWS_A, 4'd1),
			cfg_step(REG_COLS_B, 4'd1),
			cfg_step(REG_OP_MODE, CFG_DATA_W'(OP_MUL)),
			item_step(CMD_RUN, 3'd0, 3'd0, 32'h0)
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		busy = 1'b0;
		foreach (directed_steps[n]) begin
			st = directed_steps[n];
			if (st.is_cfg) begin
				if (busy)
					wait_quiet();
				busy = 1'b0;
				cfg_write(st.reg_idx, st.reg_val);
			end else begin
				send_item(st.cmd, st.row, st.col, st.val, !st.typed);
				if (st.typed)
					pending_elems.push_back(st.want);
				busy = 1'b1;
			end
		end

		item_target = items_sent + RANDOM_ITEMS;
		phase_no = 0;
		pressure_done = 1'b0;
		while (items_sent < item_target) begin
			wait_quiet();
			gapless = ($urandom_range(0, 3) == 0);
			if (phase_no < 2 || $urandom_range(0, 9) == 0) begin
				// one dimension of each matrix at its largest, the others at one
				case (phase_no < 2 ? phase_no : $urandom_range(0, 3))
					0: begin ra = 4'd8; ca = 4'd1; rb = 4'd1; cb = 4'd8; op = OP_MUL; end
					1: begin ra = 4'd1; ca = 4'd8; rb = 4'd8; cb = 4'd1; op = OP_MUL; end
					2: begin ra = 4'd8; ca = 4'd1; rb = 4'd8; cb = 4'd1; op = OP_ADD; end
					default: begin ra = 4'd1; ca = 4'd8; rb = 4'd1; cb = 4'd8; op = OP_SUB; end
				endcase
			end else begin
				ra = 4'($urandom_range(1, 3));
				ca = 4'($urandom_range(1, 3));
				op = MODE_W'($urandom_range(0, 2));
				if (op == OP_MUL) begin
					rb = ca;
					cb = 4'($urandom_range(1, 3));
				end else begin
					rb = ra;
					cb = ca;
				end
				if ($urandom_range(0, 4) == 0) begin
					case ($urandom_range(0, 2))
						0: begin
							bad = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
							case ($urandom_range(0, 3))
								0: ra = bad;
								1: ca = bad;
								2: rb = bad;
								default: cb = bad;
							endcase
						end
						1: op = OP_SPARE;
						default: rb = (rb % 4'd8) + 4'd1;
					endcase
				end
			end
			cfg_write(REG_ROWS_A, ra);
			cfg_write(REG_COLS_A, ca);
			cfg_write(REG_ROWS_B, rb);
			cfg_write(REG_COLS_B, cb);
			cfg_write(REG_OP_MODE, {2'($urandom()), op});
			if ($urandom_range(0, 7) == 0)
				cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 4'($urandom()));

			runs = $urandom_range(1, 2);
			repeat (runs) begin
				repeat ($urandom_range(0, 5)) stray_write();
				if (dims_conform())
					load_operands();
				if (!pressure_done && phase_no >= 3 && dims_conform() &&
						dim_ra * ((op_sel == OP_MUL) ? dim_cb : dim_ca) > 2) begin
					// output held off while more items keep coming
					hold_off_req = 1'b1;
					send_item(CMD_RUN, IDX_W'($urandom()), IDX_W'($urandom()), $urandom(), 1'b1);
					repeat (4) stray_write();
					pressure_done = 1'b1;
				end else begin
					send_item(CMD_RUN, IDX_W'($urandom()), IDX_W'($urandom()), $urandom(), 1'b1);
				end
			end
			phase_no++;
		end

		wait_quiet();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/imx_pkg.sv
rtl/core/imx_alu.sv
rtl/core/integer_matrix_add_sub_multiply_core.sv
tb/integer_matrix_add_sub_multiply_core_test.sv
